>>> src/appointment_date_sorter_macros.svh
// assertion macros for the appointment date sorter checker
// expects clk and arst_n in the scope of each use
`ifndef APPOINTMENT_DATE_SORTER_MACROS_SVH
`define APPOINTMENT_DATE_SORTER_MACROS_SVH

// same-cycle implication
`define ADS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ADS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/ads_pkg.sv
// shared types and constants for the appointment date sorter
// no dependencies
`default_nettype none

package ads_pkg;

	localparam int unsigned MIN_PER_HOUR = 60;
	localparam int unsigned KEY_W        = 34;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  start_hour;
		logic [5:0]  start_minute;
		logic [4:0]  end_hour;
		logic [5:0]  end_minute;
		logic [15:0] label_tag;
		logic        is_last;
	} in_word_t;

	typedef struct packed {
		logic [13:0] year_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [4:0]  start_hour_out;
		logic [5:0]  start_minute_out;
		logic [4:0]  end_hour_out;
		logic [5:0]  end_minute_out;
		logic [15:0] label_tag_out;
		logic        overflowed;
		logic        final_record;
	} out_word_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  start_hour;
		logic [5:0]  start_minute;
		logic [4:0]  end_hour;
		logic [5:0]  end_minute;
		logic [15:0] label_tag;
	} rec_t;

	typedef logic [KEY_W-1:0] key_t;

endpackage

`default_nettype wire

>>> src/appointment_date_sorter.sv
// appointment date sorter top level: record store and selection scan
// depends on ads_pkg
//
// channel | dir | handshake             | word
// in      | in  | in_valid / in_ready   | in_word  (ads_pkg::in_word_t)
// out     | out | out_valid / out_ready | out_word (ads_pkg::out_word_t)
//
// loading takes one cycle per word, one write into the record store while it
// has room; a word that finds the store full sets the overflow flag instead
// each output word costs one full scan of the n stored records through the
// single store read port, plus any output stall
// reset clears count, overflow flag and scan marks; the store is not cleared
// input is held off from the last word of a load until the final output word
`default_nettype none

module appointment_date_sorter #(
	parameter int unsigned MAX_ENTRIES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire ads_pkg::in_word_t in_word,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output ads_pkg::out_word_t     out_word
);
	import ads_pkg::*;

	localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic                   ovf_q;
	logic [CW-1:0]          rd_cnt_q;
	logic [CW-1:0]          out_cnt_q;
	logic                   last_vld_q;
	key_t                   last_key_q;
	logic [AW-1:0]          last_idx_q;
	logic                   vld_s1;
	logic [AW-1:0]          idx_s1;
	rec_t                   rd_data_s1;
	logic                   best_vld_q;
	logic [AW-1:0]          best_idx_q;
	rec_t                   best_rec_q;
	key_t                   best_key_q;
	logic                   out_valid_q;
	out_word_t              out_word_q;

	rec_t                   mem [MAX_ENTRIES];

	logic                   in_go;
	logic                   has_room;
	logic                   wr_en;
	logic [AW-1:0]          rd_addr;
	logic                   rd_en;
	logic [10:0]            cur_mins;
	key_t                   cur_key;
	logic                   elig_s1;
	logic                   take_s1;
	logic                   emit_go;
	logic [CW-1:0]          out_cnt_nx;
	logic                   is_final;
	rec_t                   in_rec;

	assign in_ready  = (state_q == ST_LOAD);
	assign in_go     = in_valid && in_ready;
	assign has_room  = (count_q < CW'(MAX_ENTRIES));
	assign wr_en     = in_go && has_room;
	assign rd_en     = (state_q == ST_SCAN) && (rd_cnt_q != count_q);
	assign rd_addr   = rd_cnt_q[AW-1:0];

	assign in_rec = '{
		year:         in_word.year,
		month:        in_word.month,
		day:          in_word.day,
		start_hour:   in_word.start_hour,
		start_minute: in_word.start_minute,
		end_hour:     in_word.end_hour,
		end_minute:   in_word.end_minute,
		label_tag:    in_word.label_tag
	};

	// start time in minutes, raw bits
	assign cur_mins = 11'(rd_data_s1.start_hour) * 11'(MIN_PER_HOUR)
		+ 11'(rd_data_s1.start_minute);
	assign cur_key  = {rd_data_s1.year, rd_data_s1.month, rd_data_s1.day, cur_mins};

	// only records past the last emitted key and index
	assign elig_s1 = !last_vld_q || (cur_key > last_key_q)
		|| ((cur_key == last_key_q) && (idx_s1 > last_idx_q));

	// strict less keeps the lowest index among equal keys
	assign take_s1 = vld_s1 && elig_s1 && (!best_vld_q || (cur_key < best_key_q));

	assign emit_go    = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign out_cnt_nx = CW'(out_cnt_q + CW'(1));
	assign is_final   = (out_cnt_nx == count_q);

	// record store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= in_rec;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			rd_cnt_q   <= '0;
			out_cnt_q  <= '0;
			last_vld_q <= 1'b0;
			last_key_q <= '0;
			last_idx_q <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			best_vld_q <= 1'b0;
			best_idx_q <= '0;
		end else begin
			vld_s1 <= rd_en;
			if (rd_en) begin
				idx_s1 <= rd_addr;
			end
			if (take_s1) begin
				best_vld_q <= 1'b1;
				best_idx_q <= idx_s1;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_go) begin
						if (has_room) begin
							count_q <= CW'(count_q + CW'(1));
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_word.is_last) begin
							state_q    <= ST_SCAN;
							rd_cnt_q   <= '0;
							out_cnt_q  <= '0;
							best_vld_q <= 1'b0;
							last_vld_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_cnt_q <= CW'(rd_cnt_q + CW'(1));
					end else if (!vld_s1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_cnt_q <= out_cnt_nx;
						if (is_final) begin
							state_q <= ST_LOAD;
							count_q <= '0;
							ovf_q   <= 1'b0;
						end else begin
							state_q    <= ST_SCAN;
							rd_cnt_q   <= '0;
							best_vld_q <= 1'b0;
							last_vld_q <= 1'b1;
							last_key_q <= best_key_q;
							last_idx_q <= best_idx_q;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			best_rec_q <= rd_data_s1;
			best_key_q <= cur_key;
		end
		if (emit_go) begin
			out_word_q <= '{
				year_out:         best_rec_q.year,
				month_out:        best_rec_q.month,
				day_out:          best_rec_q.day,
				start_hour_out:   best_rec_q.start_hour,
				start_minute_out: best_rec_q.start_minute,
				end_hour_out:     best_rec_q.end_hour,
				end_minute_out:   best_rec_q.end_minute,
				label_tag_out:    best_rec_q.label_tag,
				overflowed:       ovf_q,
				final_record:     is_final
			};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire

>>> src/ads_checker.sv
// port-level checks for the appointment date sorter, with its bind
// depends on ads_pkg and appointment_date_sorter_macros.svh
`default_nettype none

`include "appointment_date_sorter_macros.svh"

module ads_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire ads_pkg::in_word_t  in_word,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire ads_pkg::out_word_t out_word
);
	import ads_pkg::*;

	`ADS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "output word changed while stalled")
	`ADS_ASSERT_NEXT(a_last_closes, in_valid && in_ready && in_word.is_last, !in_ready, "input still open after last word")
	`ADS_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_word), "input word changed while stalled")
	`ADS_ASSERT_NOW(a_load_final, in_ready && out_valid, out_word.final_record, "non-final word pending while loading")

endmodule

bind appointment_date_sorter ads_checker u_ads_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

`default_nettype wire
